>>> hw/rtl/sptm_pkg.sv
`default_nettype none

package sptm_pkg;

    // Block size. The permutation holds one entry per coefficient.
    localparam int NUM_COEFFS = 256;
    localparam int MSG_BYTES  = 32;

    localparam int MSG_BITS = MSG_BYTES * 8;
    localparam int PERM_AW  = $clog2(NUM_COEFFS);
    localparam int CNT_W    = $clog2(NUM_COEFFS + 1);
    localparam int EMIT_W   = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    // Item field widths.
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 8;
    localparam int COEF_W = 12;
    localparam int RND_W  = 8;
    localparam int DATA_W = 8;
    localparam int POS_W  = 8;

    // Packed input data: index, coefficient, random byte from the lowest bit up.
    localparam int S_IDX_LSB  = 0;
    localparam int S_COEF_LSB = S_IDX_LSB + IDX_W;
    localparam int S_RND_LSB  = S_COEF_LSB + COEF_W;
    localparam int S_TDATA_W  = ((S_RND_LSB + RND_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;

    // Compression constants.
    localparam logic [13:0] ROUND_ADD = 14'd1665;
    localparam logic [16:0] MUL_K     = 17'd80635;
    localparam int          BIT_POS   = 28;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD,
        CMD_SHUFFLE,
        CMD_RUN,
        CMD_READ
    } cmd_t;

    // One message bit from one coefficient: (((2c + 1665) * 80635) >> 28) & 1.
    function automatic logic coeff_bit(input logic [COEF_W-1:0] c);
        logic [13:0] t;
        logic [30:0] prod;
        t    = {1'b0, c, 1'b0} + ROUND_ADD;
        prod = 31'(t) * 31'(MUL_K);
        return prod[BIT_POS];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sptm_ram.sv
`default_nettype none

module sptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/shuffled_poly_to_message.sv
`default_nettype none

// Polynomial-to-message compression with a shuffled visiting order.
// Input items arrive on the s_ channel; tuser carries the command and tdata
// the index, coefficient and random byte. Result items leave on the m_
// channel with the byte in tdata[7:0], its position in tdata[15:8] and tlast
// marking the final item caused by one command.
// A load writes the coefficient memory. A shuffle step reduces the random
// byte modulo (position + 1) with a restoring subtract-and-compare unit,
// one quotient bit per cycle, and then swaps two permutation entries
// through the single read port.
// A run streams all permutation entries through a short pipeline (entry
// read, coefficient read, multiply, bit merge). Once it has drained, the
// message bytes follow one per cycle while the receiver is ready.
// A read hands out a permutation entry via ST_READ and the output register.
// s_tready is high only while the sequencer is idle; one item is worked on
// at a time. Results sit in an output register, so a stalled receiver holds
// the sequencer in its output state without losing or repeating anything.
// After reset the permutation memory is rewritten to the identity, one entry
// per cycle; s_tready stays low until all NUM_COEFFS (256) are written.
module shuffled_poly_to_message
    import sptm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // index [7:0], coefficient [19:8], random_byte [27:20], zero fill above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // data [7:0], position [15:8]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_RUN,
        ST_EMIT,
        ST_READ
    } state_t;

    state_t                          state_reg, state_next;
    logic [PERM_AW-1:0]              init_cnt_reg, init_cnt_next;
    logic [7:0]                      pos_reg, pos_next;
    logic [RND_W-1:0]                rnd_reg, rnd_next;
    logic [8:0]                      rem_reg, rem_next;
    logic [2:0]                      div_cnt_reg, div_cnt_next;
    logic [7:0]                      a_reg, a_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                run_cnt_reg, run_cnt_next;
    logic                            v1_reg, v1_next;
    logic                            v2_reg, v2_next;
    logic                            v3_reg, v3_next;
    logic [7:0]                      p1_reg, p1_next;
    logic [7:0]                      p2_reg, p2_next;
    logic                            bit_reg, bit_next;
    logic [MSG_BYTES-1:0][7:0]       msg_reg, msg_next;
    logic [EMIT_W-1:0]               emit_cnt_reg, emit_cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]            m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;

    // Permutation memory port.
    logic                            perm_we;
    logic [PERM_AW-1:0]              perm_waddr, perm_raddr;
    logic [7:0]                      perm_wdata, perm_rdata;

    // Coefficient memory port.
    logic                            coef_we;
    logic [PERM_AW-1:0]              coef_raddr;
    logic [COEF_W-1:0]               coef_rdata;

    logic [IDX_W-1:0]                in_index;
    logic [COEF_W-1:0]               in_coef;
    logic [RND_W-1:0]                in_rnd;
    logic                            in_accept;
    logic                            out_free;
    logic                            idx_in_range;
    logic [8:0]                      divisor;
    logic [8:0]                      rem_shift;

    assign in_index  = s_tdata[S_IDX_LSB +: IDX_W];
    assign in_coef   = s_tdata[S_COEF_LSB +: COEF_W];
    assign in_rnd    = s_tdata[S_RND_LSB +: RND_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign idx_in_range = ({1'b0, idx_reg} < 9'(NUM_COEFFS));

    // Restoring step: shift in one dividend bit, subtract if it fits.
    assign divisor   = {1'b0, pos_reg} + 9'd1;
    assign rem_shift = {rem_reg[7:0], rnd_reg[RND_W-1]};

    assign coef_we = in_accept && (cmd_t'(s_tuser) == CMD_LOAD)
                     && ({1'b0, in_index} < 9'(NUM_COEFFS));
    // The permutation entry read in the previous cycle addresses the
    // coefficient memory directly during a run.
    assign coef_raddr = perm_rdata[PERM_AW-1:0];

    sptm_ram #(
        .WIDTH (8),
        .DEPTH (NUM_COEFFS)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    sptm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (NUM_COEFFS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (in_index[PERM_AW-1:0]),
        .wdata (in_coef),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        pos_next      = pos_reg;
        rnd_next      = rnd_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        a_next        = a_reg;
        idx_next      = idx_reg;
        run_cnt_next  = run_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        msg_next      = msg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        perm_we    = 1'b0;
        perm_waddr = init_cnt_reg;
        perm_wdata = 8'(init_cnt_reg);
        perm_raddr = in_index[PERM_AW-1:0];

        // Run pipeline: entry read, coefficient read, bit, merge.
        v1_next  = 1'b0;
        v2_next  = v1_reg;
        v3_next  = v2_reg;
        p1_next  = perm_rdata;
        p2_next  = p1_reg;
        bit_next = coeff_bit(coef_rdata);

        if (v3_reg && bit_reg && ({1'b0, p2_reg} < 9'(MSG_BITS))) begin
            msg_next[p2_reg[3 +: EMIT_W]][p2_reg[2:0]] = 1'b1;
        end

        case (state_reg)
            ST_INIT: begin
                perm_we       = 1'b1;
                init_cnt_next = init_cnt_reg + PERM_AW'(1);
                if (init_cnt_reg == PERM_AW'(NUM_COEFFS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    case (cmd_t'(s_tuser))
                        CMD_LOAD: begin
                            state_next = ST_IDLE;
                        end
                        CMD_SHUFFLE: begin
                            rnd_next     = in_rnd;
                            rem_next     = '0;
                            div_cnt_next = '0;
                            state_next   = ST_DIV;
                        end
                        CMD_RUN: begin
                            msg_next     = '0;
                            run_cnt_next = '0;
                            state_next   = ST_RUN;
                        end
                        CMD_READ: begin
                            idx_next   = in_index;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rnd_next     = rnd_reg << 1;
                div_cnt_next = div_cnt_reg + 3'd1;
                if (rem_shift >= divisor) begin
                    rem_next = rem_shift - divisor;
                end else begin
                    rem_next = rem_shift;
                end
                if (div_cnt_reg == 3'd7) begin
                    state_next = ST_SW_RA;
                end
            end
            ST_SW_RA: begin
                perm_raddr = pos_reg[PERM_AW-1:0];
                state_next = ST_SW_RB;
            end
            ST_SW_RB: begin
                perm_raddr = rem_reg[PERM_AW-1:0];
                a_next     = perm_rdata;
                state_next = ST_SW_WA;
            end
            ST_SW_WA: begin
                perm_we    = 1'b1;
                perm_waddr = pos_reg[PERM_AW-1:0];
                perm_wdata = perm_rdata;
                state_next = ST_SW_WB;
            end
            ST_SW_WB: begin
                perm_we    = 1'b1;
                perm_waddr = rem_reg[PERM_AW-1:0];
                perm_wdata = a_reg;
                if (pos_reg <= 8'd1) begin
                    pos_next = 8'(NUM_COEFFS - 1);
                end else begin
                    pos_next = pos_reg - 8'd1;
                end
                state_next = ST_IDLE;
            end
            ST_RUN: begin
                perm_raddr = run_cnt_reg[PERM_AW-1:0];
                if (run_cnt_reg < CNT_W'(NUM_COEFFS)) begin
                    v1_next      = 1'b1;
                    run_cnt_next = run_cnt_reg + CNT_W'(1);
                end else if (!v1_reg && !v2_reg && !v3_reg) begin
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({8'(emit_cnt_reg), msg_reg[emit_cnt_reg]});
                    m_tlast_next  = (emit_cnt_reg == EMIT_W'(MSG_BYTES - 1));
                    if (emit_cnt_reg == EMIT_W'(MSG_BYTES - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_cnt_next = emit_cnt_reg + EMIT_W'(1);
                    end
                end
            end
            ST_READ: begin
                // Hold the address so the registered read stays on this entry.
                perm_raddr = idx_reg[PERM_AW-1:0];
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({idx_reg,
                                                idx_in_range ? perm_rdata : 8'd0});
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            pos_reg      <= 8'(NUM_COEFFS - 1);
            div_cnt_reg  <= '0;
            run_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            pos_reg      <= pos_next;
            div_cnt_reg  <= div_cnt_next;
            run_cnt_reg  <= run_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            v3_reg       <= v3_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rnd_reg     <= rnd_next;
        rem_reg     <= rem_next;
        a_reg       <= a_next;
        idx_reg     <= idx_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        bit_reg     <= bit_next;
        msg_reg     <= msg_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // The shuffle position never reaches zero, so the divisor is at least two.
    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 8'd0)
        else $error("shuffle position reached zero");

    // The swap index produced by the divider is below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SW_RA) |-> (rem_reg < divisor))
        else $error("shuffle remainder not below divisor");

    // Message bytes are only handed out once the run pipeline has drained.
    a_drained_before_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("run pipeline busy while emitting");

    // The run counter never passes the number of coefficients.
    a_run_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_cnt_reg <= CNT_W'(NUM_COEFFS))
        else $error("run counter out of range");
`endif

endmodule

`default_nettype wire
